[rtl/core/hpsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall position and speed counter package
// Shared word types, command and status codes, and arithmetic constants for
// the hall sensor position decoder and speed estimator.
// ----------------------------------------------------------------------------
package hpsc_pkg;

   // Command codes carried in the request word.
   localparam logic [1:0] CMD_HALL_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_SPEED_READ  = 2'd1;
   localparam logic [1:0] CMD_RESET       = 2'd2;

   // Speed status codes carried in the response word.
   localparam logic [1:0] STAT_OK            = 2'd0;
   localparam logic [1:0] STAT_NOT_READ      = 2'd1;
   localparam logic [1:0] STAT_ZERO_INTERVAL = 2'd2;
   localparam logic [1:0] STAT_SATURATED     = 2'd3;

   // Control register indexes.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CPR   = 1'b1;

   // Field widths.
   localparam int SCALE_W = 16;
   localparam int CPR_W   = 12;
   localparam int TIME_W  = 32;
   localparam int CS_W    = CPR_W + SCALE_W;
   localparam int DEN_W   = CS_W + TIME_W;

   // 60000 * 256 = 7500 * 2^11: a 13-bit constant product and a shift.
   localparam int RPM_MULT_W = 13;
   localparam logic [RPM_MULT_W-1:0] RPM_MULT = 13'd7500;
   localparam int RPM_SHIFT = 11;

   // The quotient is developed to 33 bits, enough for both saturation limits.
   localparam int QUO_W = 33;
   localparam int ITER_W = 6;
   localparam logic [QUO_W-1:0] LIMIT_POS = 33'h0_7FFF_FFFF;
   localparam logic [QUO_W-1:0] LIMIT_NEG = 33'h0_8000_0000;

   typedef struct packed {
      logic [1:0]        command;
      logic [2:0]        hall_levels;
      logic [TIME_W-1:0] time_ms;
   } hpsc_req_type;

   typedef struct packed {
      logic signed [31:0] position_count;
      logic signed [31:0] speed_rpm;
      logic [1:0]         speed_status;
   } hpsc_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic delta;
      logic mult;
      logic denom;
      logic check;
      logic divide;
      logic finish;
   } hpsc_cmd_bus_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_read;
      logic div_last;
      logic out_free;
   } hpsc_status_type;

   // Next code of the forward six-step sequence 1-3-2-6-4-5-1.
   function automatic logic [2:0] hall_next_fwd(input logic [2:0] code);
      logic [2:0] nxt;
      unique case (code)
         3'd1:    nxt = 3'd3;
         3'd2:    nxt = 3'd6;
         3'd3:    nxt = 3'd2;
         3'd4:    nxt = 3'd5;
         3'd5:    nxt = 3'd1;
         3'd6:    nxt = 3'd4;
         default: nxt = 3'd0;
      endcase
      return nxt;
   endfunction

   function automatic logic hall_code_valid(input logic [2:0] code);
      return (code != 3'd0) && (code != 3'd7);
   endfunction

endpackage

[rtl/core/hpsc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall position and speed counter controller
// Sequences one word at a time through the datapath: capture, the speed
// arithmetic steps and the iterative divider, then the result hand-over.
// ----------------------------------------------------------------------------
module hpsc_ctrl
   import hpsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hpsc_status_type  status,
   output hpsc_cmd_bus_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELTA,
      ST_MULT,
      ST_DENOM,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_is_read ? ST_DELTA : ST_FINISH;
            end
         end
         ST_DELTA:  state_in = ST_MULT;
         ST_MULT:   state_in = ST_DENOM;
         ST_DENOM:  state_in = ST_CHECK;
         ST_CHECK:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command decode.
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.delta  = (state_ff == ST_DELTA);
      cmd.mult   = (state_ff == ST_MULT);
      cmd.denom  = (state_ff == ST_DENOM);
      cmd.check  = (state_ff == ST_CHECK);
      cmd.divide = (state_ff == ST_DIVIDE);
      cmd.finish = (state_ff == ST_FINISH) && status.out_free;
   end

endmodule

[rtl/core/hpsc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall position and speed counter datapath
// Holds the control registers, position and timing state, the speed
// arithmetic with its restoring divider, and the response output register.
// ----------------------------------------------------------------------------
module hpsc_datapath
   import hpsc_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  hpsc_req_type          req_word,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output hpsc_rsp_type          rsp_word,
   input  hpsc_cmd_bus_type      cmd,
   output hpsc_status_type       status
);

   localparam int PROD_W = COUNT_WIDTH + RPM_MULT_W;
   localparam int NUM_W  = PROD_W + RPM_SHIFT;
   localparam int CMP_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   // Control registers.
   logic [SCALE_W-1:0] scale_ff;
   logic [CPR_W-1:0]   cpr_ff;

   // Architectural state.
   logic [2:0]             last_code_ff,  last_code_in;
   logic [COUNT_WIDTH-1:0] pos_ff,        pos_in;
   logic [COUNT_WIDTH-1:0] pos_read_ff,   pos_read_in;
   logic [TIME_W-1:0]      start_ff,      start_in;

   // Captured request word.
   logic [1:0]        cmd_ff;
   logic [2:0]        hall_ff;
   logic [TIME_W-1:0] time_ff;

   // Speed arithmetic registers.
   logic [TIME_W-1:0]      dt_ff;
   logic [COUNT_WIDTH-1:0] mag_ff;
   logic                   neg_ff;
   logic [NUM_W-1:0]       numer_ff;
   logic [CS_W-1:0]        cs_ff;
   logic [DEN_W-1:0]       den_ff;
   logic                   ovf_ff;
   logic [DEN_W-1:0]       rem_ff;
   logic [QUO_W-1:0]       low_ff;
   logic [QUO_W-1:0]       quo_ff;
   logic [ITER_W-1:0]      iter_ff;

   // Response register.
   logic         rsp_valid_ff;
   hpsc_rsp_type rsp_word_ff, rsp_word_in;

   logic [COUNT_WIDTH-1:0] delta;
   logic [PROD_W-1:0]      prod;
   logic [DEN_W:0]         rem_sh;
   logic                   q_bit;
   logic [QUO_W-1:0]       limit;

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_W'(256);
         cpr_ff   <= CPR_W'(31);
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_SCALE: scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_CPR:   cpr_ff   <= csr_wdata[CPR_W-1:0];
            default:   ;
         endcase
      end
   end

   // Capture the accepted word.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_word.command;
         hall_ff <= req_word.hall_levels;
         time_ff <= req_word.time_ms;
      end
   end

   // Count change, its magnitude and the interval length.
   assign delta = pos_ff - pos_read_ff;

   always_ff @(posedge clock) begin
      if (cmd.delta) begin
         dt_ff  <= time_ff - start_ff;
         neg_ff <= delta[COUNT_WIDTH-1];
         mag_ff <= delta[COUNT_WIDTH-1] ? (~delta + COUNT_WIDTH'(1)) : delta;
      end
   end

   // Numerator and the first half of the denominator.
   assign prod = PROD_W'(mag_ff) * PROD_W'(RPM_MULT);

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         numer_ff <= {prod, {RPM_SHIFT{1'b0}}};
         cs_ff    <= CS_W'(cpr_ff) * CS_W'(scale_ff);
      end
   end

   // Full denominator.
   always_ff @(posedge clock) begin
      if (cmd.denom) begin
         den_ff <= DEN_W'(cs_ff) * DEN_W'(dt_ff);
      end
   end

   // Restoring divider step: one quotient bit a cycle.
   assign rem_sh = {rem_ff, low_ff[QUO_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         // A quotient that needs more than 33 bits, or a zero divisor, saturates.
         ovf_ff  <= (den_ff == '0) ||
                    (CMP_W'(numer_ff) >= (CMP_W'(den_ff) << QUO_W));
         rem_ff  <= DEN_W'(numer_ff >> QUO_W);
         low_ff  <= numer_ff[QUO_W-1:0];
         quo_ff  <= '0;
         iter_ff <= ITER_W'(QUO_W - 1);
      end else if (cmd.divide) begin
         rem_ff  <= q_bit ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         low_ff  <= {low_ff[QUO_W-2:0], 1'b0};
         quo_ff  <= {quo_ff[QUO_W-2:0], q_bit};
         iter_ff <= iter_ff - ITER_W'(1);
      end
   end

   assign limit = neg_ff ? LIMIT_NEG : LIMIT_POS;

   // Result and state update for the word in hand.
   always_comb begin
      last_code_in = last_code_ff;
      pos_in       = pos_ff;
      pos_read_in  = pos_read_ff;
      start_in     = start_ff;
      rsp_word_in.speed_rpm    = '0;
      rsp_word_in.speed_status = STAT_NOT_READ;
      unique case (cmd_ff)
         CMD_HALL_SAMPLE: begin
            if (hall_code_valid(hall_ff) && hall_code_valid(last_code_ff)) begin
               if (hall_next_fwd(last_code_ff) == hall_ff) begin
                  pos_in = pos_ff + COUNT_WIDTH'(1);
               end else if (hall_next_fwd(hall_ff) == last_code_ff) begin
                  pos_in = pos_ff - COUNT_WIDTH'(1);
               end
            end
            last_code_in = hall_ff;
         end
         CMD_SPEED_READ: begin
            priority if (dt_ff == '0) begin
               rsp_word_in.speed_status = STAT_ZERO_INTERVAL;
            end else if (mag_ff == '0) begin
               rsp_word_in.speed_status = STAT_OK;
            end else if (ovf_ff || (quo_ff > limit)) begin
               rsp_word_in.speed_rpm    = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               rsp_word_in.speed_status = STAT_SATURATED;
            end else begin
               rsp_word_in.speed_rpm    = neg_ff ? -signed'(quo_ff[31:0])
                                                 : signed'(quo_ff[31:0]);
               rsp_word_in.speed_status = STAT_OK;
            end
            pos_read_in = pos_ff;
            start_in    = time_ff;
         end
         CMD_RESET: begin
            last_code_in = '0;
            pos_in       = '0;
            pos_read_in  = '0;
            start_in     = time_ff;
         end
         default: ;
      endcase
      rsp_word_in.position_count = 32'(signed'(pos_in));
   end

   // Architectural state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_code_ff <= '0;
         pos_ff       <= '0;
         pos_read_ff  <= '0;
         start_ff     <= '0;
      end else if (cmd.finish) begin
         last_code_ff <= last_code_in;
         pos_ff       <= pos_in;
         pos_read_ff  <= pos_read_in;
         start_ff     <= start_in;
      end
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign status.req_is_read = (req_word.command == CMD_SPEED_READ);
   assign status.div_last    = (iter_ff == '0);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

[rtl/core/hall_position_speed_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall position and speed counter
// Decodes three-phase hall codes into a signed position count and turns
// count changes over a millisecond interval into a speed in rpm.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                           Moves
//  req      in         req_valid/req_ready, req_word   one command word
//  rsp      out        rsp_valid/rsp_ready, rsp_word   one result word per req
//  csr      in         csr_wen, csr_index, csr_wdata   one register write
//
//  A hall sample, reset or unused command goes from acceptance to finish.
//  A speed read adds delta, mult, denom, check and 33 restoring divider steps.
//  One word is in flight at a time; the next is taken while a result waits.
//  A stalled response holds only the finish step; reset is synchronous.
// ----------------------------------------------------------------------------
module hall_position_speed_counter
   import hpsc_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hpsc_req_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hpsc_rsp_type          rsp_word
);

   hpsc_cmd_bus_type cmd;
   hpsc_status_type  status;

   // Sequencer.
   hpsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and state.
   hpsc_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[rtl/core/hpsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall position and speed counter checker
// Port-level properties of the counter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hpsc_checker
   import hpsc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input hpsc_rsp_type rsp_word
);

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // The block works on one word at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in progress");

   // Anything other than a speed read reports no speed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.speed_status == STAT_NOT_READ) |-> rsp_word.speed_rpm == 0)
      else $error("speed reported for a non-read word");

   // A zero interval reports no speed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.speed_status == STAT_ZERO_INTERVAL)
      |-> rsp_word.speed_rpm == 0)
      else $error("speed reported for a zero interval");

   // Saturation gives one of the two limits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.speed_status == STAT_SATURATED)
      |-> (rsp_word.speed_rpm == 32'sh7FFF_FFFF) || (rsp_word.speed_rpm == 32'sh8000_0000))
      else $error("saturated speed is not a limit value");

endmodule

bind hall_position_speed_counter hpsc_checker u_hpsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

[sim/hall_position_speed_counter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall position and speed counter testbench
// Sends command words through the request channel while both channels stall
// at random. Each result word is checked against a cycle-free model of the
// position counter and speed estimator kept in this bench. A short directed
// table comes first, then random hall rotations with reads and resets under
// several register settings, including zero and extreme divisors.
// ----------------------------------------------------------------------------
module hall_position_speed_counter_tb;
   import hpsc_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam longint unsigned RPM_NUMERATOR = 64'd15360000;
   localparam int SETTLE_CYCLES = 40;
   localparam int NUM_PHASES = 7;
   localparam int DIRECTED_ROWS = 25;

   typedef struct {
      hpsc_req_type word;
      bit           fixed;
      hpsc_rsp_type want;
   } stim_row_type;

   typedef struct {
      logic [15:0] scale;
      logic [15:0] cpr;
      int          words;
      int          read_pm;
      int          flip_pm;
      int          dt_max;
      bit          random_regs;
   } phase_plan_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   hpsc_req_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hpsc_rsp_type rsp_word;

   // Bench copy of the block's registers and state.
   logic [15:0] cfg_scale;
   logic [11:0] cfg_cpr;
   logic [2:0] prev_code;
   logic [31:0] pos_now;
   logic [31:0] pos_at_read;
   logic [31:0] t_start;

   // Forward and reverse neighbours in the six-step sequence.
   logic [2:0] step_up [8];
   logic [2:0] step_dn [8];

   hpsc_rsp_type result_due [$];
   stim_row_type dir_tab [DIRECTED_ROWS];
   phase_plan_type plans [NUM_PHASES];

   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int reads_sent = 0;
   int reads_saturated = 0;
   int reads_zero_dt = 0;
   int send_calm = 0;
   int rsp_calm = 0;
   int rsp_hold = 0;

   // Stimulus generator state.
   logic [2:0] gen_code = 3'd0;
   bit gen_up = 1'b1;
   logic [31:0] now_ms = 32'd0;

   hall_position_speed_counter dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   function automatic bit code_ok(input logic [2:0] c);
      return (c >= 3'd1) && (c <= 3'd6);
   endfunction

   // Applies one command word to the bench state and returns its result word.
   function automatic hpsc_rsp_type advance_counter(input hpsc_req_type w);
      hpsc_rsp_type r;
      logic [31:0] dt;
      logic [31:0] delta;
      logic [31:0] mag;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quo;
      logic [63:0] lim;
      logic neg;
      r.speed_rpm = '0;
      r.speed_status = STAT_NOT_READ;
      case (w.command)
         CMD_HALL_SAMPLE: begin
            if (code_ok(w.hall_levels) && code_ok(prev_code)) begin
               if (step_up[prev_code] == w.hall_levels) pos_now = pos_now + 32'd1;
               else if (step_dn[prev_code] == w.hall_levels) pos_now = pos_now - 32'd1;
            end
            prev_code = w.hall_levels;
         end
         CMD_SPEED_READ: begin
            dt = w.time_ms - t_start;
            delta = pos_now - pos_at_read;
            neg = delta[31];
            mag = neg ? (32'd0 - delta) : delta;
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            den = 64'(cfg_cpr) * 64'(dt) * 64'(cfg_scale);
            if (dt == 32'd0) begin
               r.speed_status = STAT_ZERO_INTERVAL;
            end else if (mag == 32'd0) begin
               r.speed_status = STAT_OK;
            end else begin
               num = 64'(mag) * RPM_NUMERATOR;
               quo = (den != 64'd0) ? (num / den) : 64'hFFFF_FFFF_FFFF_FFFF;
               if (quo > lim) begin
                  r.speed_rpm = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  r.speed_status = STAT_SATURATED;
               end else begin
                  r.speed_rpm = neg ? (32'd0 - quo[31:0]) : quo[31:0];
                  r.speed_status = STAT_OK;
               end
            end
            t_start = w.time_ms;
            pos_at_read = pos_now;
         end
         CMD_RESET: begin
            prev_code = 3'd0;
            pos_now = '0;
            pos_at_read = '0;
            t_start = w.time_ms;
         end
         default: begin
         end
      endcase
      r.position_count = pos_now;
      return r;
   endfunction

   function automatic stim_row_type row(input logic [1:0] c, input logic [2:0] h,
                                        input logic [31:0] t, input bit fx,
                                        input logic signed [31:0] p, input logic [1:0] st);
      stim_row_type s;
      s.word = '{command: c, hall_levels: h, time_ms: t};
      s.fixed = fx;
      s.want = '{position_count: p, speed_rpm: 32'sd0, speed_status: st};
      return s;
   endfunction

   // Sender gaps: mostly none or short, a few long, with calm stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      if (r < 2) begin
         send_calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // Builds one random command word, mostly clean rotations with some noise.
   function automatic hpsc_req_type make_word(input phase_plan_type pl);
      hpsc_req_type w;
      int r;
      int k;
      r = $urandom_range(0, 999);
      w.hall_levels = 3'($urandom_range(0, 7));
      w.time_ms = $urandom;
      if (r < pl.read_pm + 25) begin
         w.command = (r < pl.read_pm) ? CMD_SPEED_READ :
                     (r < pl.read_pm + 15) ? CMD_RESET : CMD_UNUSED;
         if (w.command != CMD_UNUSED) begin
            k = $urandom_range(0, 99);
            if (k < 8) now_ms = now_ms;
            else if (k < 80) now_ms = now_ms + $urandom_range(1, pl.dt_max);
            else if (k < 95) now_ms = now_ms + $urandom_range(1, 65535);
            else now_ms = $urandom;
            w.time_ms = now_ms;
         end
         if (w.command == CMD_RESET) gen_code = 3'd0;
      end else begin
         w.command = CMD_HALL_SAMPLE;
         if ($urandom_range(0, 999) < pl.flip_pm) gen_up = ~gen_up;
         if ($urandom_range(0, 99) < 88) begin
            if (!code_ok(gen_code)) w.hall_levels = 3'($urandom_range(1, 6));
            else w.hall_levels = gen_up ? step_up[gen_code] : step_dn[gen_code];
         end
         gen_code = w.hall_levels;
      end
      return w;
   endfunction

   // Offers one word, waits for the handshake and records its expected result.
   task automatic send_word(input hpsc_req_type w, input bit use_fixed,
                            input hpsc_rsp_type fixed_rsp);
      int gap;
      hpsc_rsp_type pred;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      pred = advance_counter(w);
      result_due.push_back(use_fixed ? fixed_rsp : pred);
      words_sent++;
      if (w.command == CMD_SPEED_READ) begin
         reads_sent++;
         if (pred.speed_status == STAT_SATURATED) reads_saturated++;
         if (pred.speed_status == STAT_ZERO_INTERVAL) reads_zero_dt++;
      end
   endtask

   // Holds off the sender until every result is back and the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (result_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] scale_val, input logic [15:0] cpr_val);
      csr_wen <= 1'b1;
      csr_index <= CSR_SCALE;
      csr_wdata <= scale_val;
      @(posedge clock);
      csr_index <= CSR_CPR;
      csr_wdata <= cpr_val;
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_scale = scale_val;
      cfg_cpr = cpr_val[11:0];
   endtask

   // Result channel stalls: mostly ready, short and long holds, calm stretches.
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if (r < 2) begin
         rsp_calm = $urandom_range(30, 100);
         rsp_ready <= 1'b1;
      end else if (r < 70) begin
         rsp_ready <= 1'b1;
      end else if (r < 95) begin
         rsp_hold = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_hold = $urandom_range(10, 40);
         rsp_ready <= 1'b0;
      end
   end

   // Each accepted result word is compared with the oldest expectation.
   always @(posedge clock) begin
      hpsc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (result_due.size() == 0) begin
            $display("%0t: result word with nothing expected: pos %0d speed %0d status %0d",
                     $time, rsp_word.position_count, rsp_word.speed_rpm,
                     rsp_word.speed_status);
            errors++;
         end else begin
            want = result_due.pop_front();
            words_checked++;
            if (rsp_word.position_count !== want.position_count) begin
               $display("%0t: position_count expected %0d, got %0d", $time,
                        want.position_count, rsp_word.position_count);
               errors++;
            end
            if (rsp_word.speed_rpm !== want.speed_rpm) begin
               $display("%0t: speed_rpm expected %0d, got %0d", $time,
                        want.speed_rpm, rsp_word.speed_rpm);
               errors++;
            end
            if (rsp_word.speed_status !== want.speed_status) begin
               $display("%0t: speed_status expected %0d, got %0d", $time,
                        want.speed_status, rsp_word.speed_status);
               errors++;
            end
         end
      end
   end

   // Backstop in case the block stops answering.
   initial begin
      #10_000_000;
      $display("hall_position_speed_counter_tb NOT OK");
      $finish;
   end

   initial begin
      hpsc_req_type w;
      step_up = '{3'd0, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0};
      step_dn = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};
      cfg_scale = 16'd256;
      cfg_cpr = 12'd31;
      prev_code = 3'd0;
      pos_now = '0;
      pos_at_read = '0;
      t_start = '0;

      // Directed rows: a full forward turn, two steps back, bad codes, reads and a reset.
      dir_tab = '{
         row(CMD_UNUSED,      3'd7, 32'hFFFF_FFFF, 1, 0, STAT_NOT_READ),
         row(CMD_SPEED_READ,  3'd0, 32'h0000_0000, 1, 0, STAT_ZERO_INTERVAL),
         row(CMD_HALL_SAMPLE, 3'd1, 32'h0000_0000, 1, 0, STAT_NOT_READ),
         row(CMD_HALL_SAMPLE, 3'd3, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd2, 32'h5555_5555, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd6, 32'hAAAA_AAAA, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd4, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd5, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd1, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd5, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd4, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd4, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd2, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd7, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd0, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd1, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd3, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_SPEED_READ,  3'd0, 32'd100,       0, 0, STAT_OK),
         row(CMD_SPEED_READ,  3'd7, 32'd100,       1, 5, STAT_ZERO_INTERVAL),
         row(CMD_RESET,       3'd7, 32'hFFFF_FFF0, 1, 0, STAT_NOT_READ),
         row(CMD_HALL_SAMPLE, 3'd1, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_HALL_SAMPLE, 3'd5, 32'h0000_0000, 0, 0, STAT_OK),
         row(CMD_SPEED_READ,  3'd0, 32'h0000_0005, 0, 0, STAT_OK),
         row(CMD_SPEED_READ,  3'd0, 32'hFFFF_FFFF, 0, 0, STAT_OK),
         row(CMD_UNUSED,      3'd0, 32'h0000_0000, 0, 0, STAT_OK)
      };

      // Register settings per phase; the first keeps the reset values.
      plans = '{
         '{16'd256,   16'd31,    250, 120, 20, 50, 0},
         '{16'hFFFF,  16'h0FFF,  200, 120, 20, 50, 0},
         '{16'd1,     16'd1,     300,   4,  3,  1, 0},
         '{16'd0,     16'd1234,  150, 100, 20, 50, 0},
         '{16'd300,   16'hF000,  150, 100, 20, 50, 0},
         '{16'd0,     16'd0,     250, 100, 20, 500, 1},
         '{16'd256,   16'd31,    125, 120, 20, 50, 0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_word(dir_tab[i].word, dir_tab[i].fixed, dir_tab[i].want);
      now_ms = 32'hFFFF_FFFF;
      gen_code = 3'd5;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            drain();
            if (plans[p].random_regs) set_config(16'($urandom), 16'($urandom));
            else set_config(plans[p].scale, plans[p].cpr);
         end
         for (int n = 0; n < plans[p].words; n++) begin
            w = make_word(plans[p]);
            send_word(w, 1'b0, '0);
         end
      end

      drain();
      $display("Checked %0d of %0d words over %0d register settings.", words_checked,
               words_sent, NUM_PHASES);
      $display("Speed reads: %0d, of which %0d saturated and %0d had a zero interval.",
               reads_sent, reads_saturated, reads_zero_dt);
      if (errors == 0) begin
         $display("hall_position_speed_counter_tb OK");
      end else begin
         $display("hall_position_speed_counter_tb NOT OK");
      end
      $finish;
   end

endmodule
